// File: sv/nfsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsr_pkg: shared types and constants of the scanline reader
// Holds the default frame size, the configuration register indexes, the
// controller command and status bundles and the palette lookup.
// ----------------------------------------------------------------------------
package nfsr_pkg;

  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;

  // wide enough for (width/2)*y + x/2 at the default frame size
  localparam int PROD_W = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PAL_0_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_4_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_8_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_12_15 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_RUN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EOL       = 3'd5;

  localparam logic REQ_PLOT  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef logic [3:0][63:0] palette_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_MEM,
    ST_COMPOSE
  } ctrl_state_t;

  // which kind of scanline word a fetch produces
  typedef enum logic [2:0] {
    WK_TOKEN0,
    WK_TOKEN1,
    WK_PAIR,
    WK_EOL,
    WK_ERR
  } word_kind_t;

  typedef struct packed {
    logic latch_in;
    logic calc_addr;
    logic mem_access;
    logic load_out;
    logic clear_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_fetch;
    logic clear_last;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [15:0] pal_color(input palette_t pal, input logic [3:0] idx);
    pal_color = pal[idx[3:2]][{idx[1:0], 4'b0000} +: 16];
  endfunction

endpackage

// File: sv/nfsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsr_ctrl: sequencing of the scanline reader
// Runs the clearing pass after reset, then steps one request at a time
// through address and memory phases, and for a fetch a compose phase.
// ----------------------------------------------------------------------------
module nfsr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  nfsr_pkg::ctrl_status_t status,
  output nfsr_pkg::ctrl_cmd_t    cmd
);
  import nfsr_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = ST_MEM;
      end
      ST_MEM: begin
        cmd.mem_access = 1'b1;
        state_nxt      = status.is_fetch ? ST_COMPOSE : ST_IDLE;
      end
      ST_COMPOSE: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/nfsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsr_datapath: frame store, palette and word composition
// Two nibble-wide memories hold the low and high pixel of each byte, so a
// plot writes without a read. Fetch data goes through the palette into an
// output register.
// ----------------------------------------------------------------------------
module nfsr_datapath #(
  parameter int FRAME_WIDTH  = nfsr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = nfsr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nfsr_pkg::ctrl_cmd_t            cmd,
  output nfsr_pkg::ctrl_status_t         status,
  input  logic                           cfg_we,
  input  logic [nfsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nfsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_req_type,
  input  logic [9:0]                     in_pixel_x,
  input  logic [9:0]                     in_pixel_y,
  input  logic [3:0]                     in_color_index,
  input  logic [8:0]                     in_word_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_line_word,
  output logic                           out_last_word,
  output logic                           out_range_error
);
  import nfsr_pkg::*;

  localparam int HALF_WIDTH  = FRAME_WIDTH / 2;
  localparam int STORE_BYTES = (FRAME_WIDTH * FRAME_HEIGHT) / 2;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  localparam logic [PROD_W-1:0] HALF_P     = PROD_W'(HALF_WIDTH);
  localparam logic [PROD_W-1:0] STORE_P    = PROD_W'(STORE_BYTES);
  localparam logic [10:0]       HEIGHT_L   = 11'(FRAME_HEIGHT);
  localparam logic [9:0]        EOL_POS    = 10'(HALF_WIDTH + 1);
  localparam logic [15:0]       WIDTH_TOK  = 16'(FRAME_WIDTH - 2);
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_BYTES - 1);

  // configuration
  palette_t    pal_r;
  logic [15:0] raw_tok_r;
  logic [15:0] eol_tok_r;

  // latched request
  logic       req_r;
  logic [9:0] x_r;
  logic [9:0] y_r;
  logic [3:0] clr_r;
  logic [8:0] wp_r;

  // address phase
  logic [ADDR_W-1:0] addr_r;
  logic              plot_ok_r;
  word_kind_t        kind_r;

  logic [PROD_W-1:0] base;
  logic [8:0]        offset;
  logic [PROD_W-1:0] byte_n;
  word_kind_t        kind_nxt;

  // store and read data
  logic [3:0]        mem_lo [STORE_BYTES];
  logic [3:0]        mem_hi [STORE_BYTES];
  logic [3:0]        rd_lo_r;
  logic [3:0]        rd_hi_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] wr_addr;
  logic [3:0]        wr_data;
  logic              we_lo;
  logic              we_hi;

  // output register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_word_r;
  logic        out_last_r;
  logic        out_err_r;
  logic [31:0] word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r     <= '0;
      raw_tok_r <= '0;
      eol_tok_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAL_0_3:   pal_r[0]  <= cfg_wdata;
        CFG_PAL_4_7:   pal_r[1]  <= cfg_wdata;
        CFG_PAL_8_11:  pal_r[2]  <= cfg_wdata;
        CFG_PAL_12_15: pal_r[3]  <= cfg_wdata;
        CFG_RAW_RUN:   raw_tok_r <= cfg_wdata[15:0];
        CFG_EOL:       eol_tok_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= in_req_type;
      x_r   <= in_pixel_x;
      y_r   <= in_pixel_y;
      clr_r <= in_color_index;
      wp_r  <= in_word_position;
    end
  end

  // byte index and word kind
  always_comb begin
    base     = HALF_P * PROD_W'(y_r);
    offset   = '0;
    kind_nxt = WK_PAIR;
    if (({1'b0, y_r} >= HEIGHT_L) || ({1'b0, wp_r} > EOL_POS)) begin
      kind_nxt = WK_ERR;
    end else if ({1'b0, wp_r} == EOL_POS) begin
      kind_nxt = WK_EOL;
    end else if (wp_r == 9'd0) begin
      kind_nxt = WK_TOKEN0;
    end else if (wp_r == 9'd1) begin
      kind_nxt = WK_TOKEN1;
    end
    if (req_r == REQ_PLOT) begin
      offset = x_r[9:1];
    end else if (kind_nxt == WK_PAIR) begin
      offset = wp_r - 9'd1;
    end
    byte_n = base + PROD_W'(offset);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_addr) begin
      addr_r    <= byte_n[ADDR_W-1:0];
      plot_ok_r <= (byte_n < STORE_P);
      kind_r    <= kind_nxt;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  always_comb begin
    wr_addr = cmd.clear_step ? clr_cnt_r : addr_r;
    wr_data = cmd.clear_step ? 4'h0 : clr_r;
    we_lo   = cmd.clear_step ||
              (cmd.mem_access && (req_r == REQ_PLOT) && plot_ok_r && !x_r[0]);
    we_hi   = cmd.clear_step ||
              (cmd.mem_access && (req_r == REQ_PLOT) && plot_ok_r && x_r[0]);
  end

  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem_lo[wr_addr] <= wr_data;
    end
    if (cmd.mem_access && (req_r == REQ_FETCH) && (kind_r != WK_ERR)) begin
      rd_lo_r <= mem_lo[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (we_hi) begin
      mem_hi[wr_addr] <= wr_data;
    end
    if (cmd.mem_access && (req_r == REQ_FETCH) && (kind_r != WK_ERR)) begin
      rd_hi_r <= mem_hi[addr_r];
    end
  end

  // word composition
  always_comb begin
    unique case (kind_r)
      WK_TOKEN0: word_nxt = {pal_color(pal_r, rd_lo_r), raw_tok_r};
      WK_TOKEN1: word_nxt = {pal_color(pal_r, rd_hi_r), WIDTH_TOK};
      WK_PAIR:   word_nxt = {pal_color(pal_r, rd_hi_r), pal_color(pal_r, rd_lo_r)};
      WK_EOL:    word_nxt = {eol_tok_r, 16'h0000};
      default:   word_nxt = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r <= word_nxt;
      out_last_r <= (kind_r == WK_EOL);
      out_err_r  <= (kind_r == WK_ERR);
    end
  end

  assign status.is_fetch   = (req_r == REQ_FETCH);
  assign status.clear_last = (clr_cnt_r == CLEAR_LAST);
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_line_word   = out_word_r;
  assign out_last_word   = out_last_r;
  assign out_range_error = out_err_r;

endmodule

// File: sv/nibble_framebuffer_scanline_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_framebuffer_scanline_reader: 4bpp palette frame store
// Plot requests write one colour nibble, fetch requests return one composed
// 32-bit scanline word through a 16-entry palette.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the frame store, one byte
// a cycle; in_stall stays high until it ends, while configuration writes
// are taken throughout. Requests are then handled one at a time: a plot
// goes through accept, byte index through the row-stride multiplier and
// memory write, and a fetch through accept, index, registered memory read,
// and palette and compose into the output register; the compose step waits
// while that register stays full under out_stall. A finished word waits in
// the output register while the next request is accepted.
module nibble_framebuffer_scanline_reader #(
  parameter int FRAME_WIDTH  = nfsr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = nfsr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [nfsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [9:0]                      in_pixel_x,
  input  logic [9:0]                      in_pixel_y,
  input  logic [3:0]                      in_color_index,
  input  logic [8:0]                      in_word_position,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [31:0]                     out_line_word,
  output logic                            out_last_word,
  output logic                            out_range_error
);
  import nfsr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencing: clearing pass, then accept / index / memory / compose
  nfsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // store, palette registers and output register
  nfsr_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_color_index   (in_color_index),
    .in_word_position (in_word_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_word    (out_line_word),
    .out_last_word    (out_last_word),
    .out_range_error  (out_range_error)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the 4bpp scanline reader
// Sends plot and fetch requests through the valid/stall channel, keeps a
// shadow frame store, palette and token set, and compares every returned
// scanline word field by field with the word it predicts. Directed corner
// requests come first, then phases of random line traffic under several
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import nfsr_pkg::*;

  localparam int FW          = FRAME_WIDTH_DEF;
  localparam int FH          = FRAME_HEIGHT_DEF;
  localparam int HALF_W      = FW / 2;
  localparam int STORE_BYTES = FW * FH / 2;

  // the clearing pass after reset is the longest spell with no handshake
  localparam int WATCHDOG_LIMIT = 4 * STORE_BYTES + 10000;
  localparam int RESET_CYCLES   = 4;
  // a plot can still be writing when the last word is back
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 16;

  localparam int RAND_PHASES    = 5;
  localparam int RAND_PER_PHASE = 390;
  localparam int PHASE_ONES     = 1;
  localparam int PHASE_ZEROS    = 2;

  typedef struct packed {
    logic [31:0] line_word;
    logic        last_word;
    logic        range_error;
  } scan_word_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  in_req_type     = REQ_PLOT;
  logic [9:0]            in_pixel_x      = '0;
  logic [9:0]            in_pixel_y      = '0;
  logic [3:0]            in_color_index  = '0;
  logic [8:0]            in_word_position = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [31:0]           out_line_word;
  logic                  out_last_word;
  logic                  out_range_error;

  // shadow copy of the block state
  logic [7:0]  frame_m [STORE_BYTES];
  logic [63:0] palette_m [4];
  logic [15:0] raw_tok_m;
  logic [15:0] eol_tok_m;
  scan_word_t  scan_words_due [$];

  // bench control and tallies
  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   fail_count = 0;
  int   sent_count = 0;
  int   plot_count = 0;
  int   plot_dropped = 0;
  int   fetch_count = 0;
  int   error_count = 0;
  int   eol_count = 0;
  int   words_checked = 0;
  int   settings_loaded = 0;
  scan_word_t got_w;
  scan_word_t want_w;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  nibble_framebuffer_scanline_reader #(
    .FRAME_WIDTH  (FW),
    .FRAME_HEIGHT (FH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_color_index   (in_color_index),
    .in_word_position (in_word_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_word    (out_line_word),
    .out_last_word    (out_last_word),
    .out_range_error  (out_range_error)
  );

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic [15:0] colour_of(input logic [3:0] n);
    return palette_m[n[3:2]][16 * n[1:0] +: 16];
  endfunction

  // applies one accepted request to the shadow state; a fetch queues the
  // scanline word it must produce
  function automatic void track_request(input logic req, input logic [9:0] x, y,
                                        input logic [3:0] clr, input logic [8:0] wp);
    int unsigned byte_n;
    logic [7:0]  b;
    scan_word_t  w;
    if (req == REQ_PLOT) begin
      plot_count++;
      byte_n = HALF_W * y + (x >> 1);
      if (byte_n < STORE_BYTES) begin
        // odd column lands in the high nibble
        if (x[0]) frame_m[byte_n][7:4] = clr;
        else frame_m[byte_n][3:0] = clr;
      end else begin
        plot_dropped++;
      end
    end else begin
      fetch_count++;
      w = '0;
      if (y >= FH || wp > HALF_W + 1) begin
        w.range_error = 1'b1;
        error_count++;
      end else if (wp == HALF_W + 1) begin
        w.line_word = {eol_tok_m, 16'h0000};
        w.last_word = 1'b1;
        eol_count++;
      end else begin
        // words 0 and 1 both read the first byte of the line
        byte_n = HALF_W * y + ((wp < 2) ? 0 : wp - 1);
        b = frame_m[byte_n];
        if (wp == 0) w.line_word = {colour_of(b[3:0]), raw_tok_m};
        else if (wp == 1) w.line_word = {colour_of(b[7:4]), 16'(FW - 2)};
        else w.line_word = {colour_of(b[7:4]), colour_of(b[3:0])};
      end
      scan_words_due.push_back(w);
    end
  endfunction

  // offers one request and waits for it to be taken; valid stays high into
  // the next request unless an idle burst follows
  task automatic send_request(input logic req, input logic [9:0] x, y,
                              input logic [3:0] clr, input logic [8:0] wp);
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_pixel_x       <= x;
    in_pixel_y       <= y;
    in_color_index   <= clr;
    in_word_position <= wp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    track_request(req, x, y, clr, wp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // a plot ignores the word position
  task automatic plot_pixel(input logic [9:0] x, y, input logic [3:0] clr);
    send_request(REQ_PLOT, x, y, clr, 9'($urandom));
  endtask

  // a fetch ignores column and colour
  task automatic fetch_word(input logic [9:0] y, input logic [8:0] wp);
    send_request(REQ_FETCH, 10'($urandom), y, 4'($urandom), wp);
  endtask

  // holds requests back until every word is home and any plot has landed
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (scan_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all register indexes, the unused ones with junk that must be
  // ignored; token writes carry junk above bit 15
  task automatic load_settings(input logic [63:0] p0, p1, p2, p3,
                               input logic [15:0] raw, eol);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      idx  = CFG_IDX_W'(i);
      data = {$urandom, $urandom};
      case (idx)
        CFG_PAL_0_3:   data = p0;
        CFG_PAL_4_7:   data = p1;
        CFG_PAL_8_11:  data = p2;
        CFG_PAL_12_15: data = p3;
        CFG_RAW_RUN:   data[15:0] = raw;
        CFG_EOL:       data[15:0] = eol;
        default: ;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(posedge clk);
      case (idx)
        CFG_PAL_0_3, CFG_PAL_4_7, CFG_PAL_8_11, CFG_PAL_12_15: palette_m[idx[1:0]] = data;
        CFG_RAW_RUN: raw_tok_m = data[15:0];
        CFG_EOL:     eol_tok_m = data[15:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // reset registers and a freshly cleared store, then a real palette
  task automatic test_cleared_frame();
    fetch_word(10'd0, 9'd0);
    fetch_word(10'(FH - 1), 9'd1);
    wait_quiet();
    load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom), 16'($urandom));
    fetch_word(10'(FH / 2), 9'd2);
    fetch_word(10'(FH - 1), 9'(HALF_W));
  endtask

  task automatic test_plot_extremes();
    plot_pixel(10'd0, 10'd0, 4'hF);
    plot_pixel(10'd1, 10'd0, 4'h1);
    plot_pixel(10'(FW - 1), 10'(FH - 1), 4'hF);
    plot_pixel(10'(FW - 2), 10'(FH - 1), 4'h0);
    // beyond the store: dropped
    plot_pixel(10'h3FF, 10'h3FF, 4'hF);
    plot_pixel(10'd0, 10'(FH), 4'h9);
    // column past the line width wraps into the next row
    plot_pixel(10'h3FF, 10'd0, 4'h7);
  endtask

  task automatic test_fetch_words();
    fetch_word(10'd0, 9'd0);
    fetch_word(10'd0, 9'd1);
    fetch_word(10'd0, 9'd2);
    fetch_word(10'(FH - 1), 9'(HALF_W));
    fetch_word(10'(FH - 1), 9'(HALF_W + 1));
    // picks up the wrapped plot above
    fetch_word(10'd1, 9'((1023 / 2) - HALF_W + 1));
  endtask

  task automatic test_range_errors();
    fetch_word(10'(FH), 9'd0);
    fetch_word(10'h3FF, 9'd5);
    fetch_word(10'd0, 9'(HALF_W + 2));
    fetch_word(10'd0, 9'h1FF);
    wait_quiet();
  endtask

  // mostly plots into one line followed by fetches from it, with some
  // fully random requests mixed in
  task automatic test_random_traffic();
    logic [9:0] line_y;
    logic [9:0] last_x;
    logic [8:0] wp;
    int         phase_end;
    int         mid_point;
    bit         mid_drained;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_quiet();
      if (phase == PHASE_ONES)
        load_settings('1, '1, '1, '1, '1, '1);
      else if (phase == PHASE_ZEROS)
        load_settings('0, '0, '0, '0, '0, '0);
      else
        load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, 16'($urandom), 16'($urandom));
      phase_end   = sent_count + RAND_PER_PHASE;
      mid_point   = sent_count + RAND_PER_PHASE / 2;
      mid_drained = 1'b0;
      idle_on     = (phase != RAND_PHASES - 1);
      last_x      = '0;
      while (sent_count < phase_end) begin
        if (phase != RAND_PHASES - 1 && $urandom_range(0, 9) == 0) idle_on = !idle_on;
        // sender holds off until the block has emptied
        if (!mid_drained && sent_count >= mid_point) begin
          wait_quiet();
          mid_drained = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          send_request(1'($urandom), 10'($urandom), 10'($urandom), 4'($urandom),
                       9'($urandom));
        end else begin
          if ($urandom_range(0, 3) == 0)
            line_y = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'(FH - 1);
          else
            line_y = 10'($urandom_range(0, FH - 1));
          repeat ($urandom_range(1, 6)) begin
            last_x = ($urandom_range(0, 7) == 0) ? 10'($urandom)
                                                  : 10'($urandom_range(0, FW - 1));
            plot_pixel(last_x, line_y, 4'($urandom));
          end
          repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 5))
              0: wp = 9'd0;
              1: wp = 9'd1;
              2: wp = 9'(HALF_W + 1);
              3: wp = 9'(last_x / 2 + 1);
              default: wp = 9'($urandom_range(2, HALF_W));
            endcase
            fetch_word(line_y, wp);
          end
        end
      end
    end
  endtask

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // each word taken is matched against the oldest outstanding fetch
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_w = '{out_line_word, out_last_word, out_range_error};
      if (scan_words_due.size() == 0) begin
        flag_failure($sformatf("unexpected word %h last %b err %b", got_w.line_word,
                               got_w.last_word, got_w.range_error));
      end else begin
        want_w = scan_words_due.pop_front();
        words_checked++;
        if (got_w.line_word !== want_w.line_word || got_w.last_word !== want_w.last_word ||
            got_w.range_error !== want_w.range_error)
          flag_failure($sformatf(
            "word %0d mismatch: expected %h last %b err %b, got %h last %b err %b",
            words_checked, want_w.line_word, want_w.last_word, want_w.range_error,
            got_w.line_word, got_w.last_word, got_w.range_error));
      end
    end
  end

  // hang detection: no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    foreach (frame_m[i]) frame_m[i] = '0;
    foreach (palette_m[i]) palette_m[i] = '0;
    raw_tok_m = '0;
    eol_tok_m = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_cleared_frame();
    test_plot_extremes();
    test_fetch_words();
    test_range_errors();
    test_random_traffic();

    idle_on = 1'b0;
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d plots (%0d outside the store), %0d fetches",
             sent_count, plot_count, plot_dropped, fetch_count);
    $display("%0d words checked, %0d range errors, %0d end-of-line words, %0d settings",
             words_checked, error_count, eol_count, settings_loaded);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
sv/nfsr_pkg.sv
sv/nfsr_ctrl.sv
sv/nfsr_datapath.sv
sv/nibble_framebuffer_scanline_reader.sv
dv/tb.sv
